FILE: sv/stai_pkg.sv
`timescale 1ns / 1ps

package stai_pkg;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_DELETE = 2'd1;
  localparam logic [1:0] KIND_MODIFY = 2'd2;
  localparam logic [1:0] KIND_READ   = 2'd3;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_FULL      = 2'd1;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
  localparam logic [1:0] STATUS_EXHAUSTED = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] record_id;
    logic [63:0] payload;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] result_id;
    logic [63:0] read_payload;
    logic [3:0]  slot_index;
  } rsp_t;

endpackage

FILE: sv/stai_store.sv
`timescale 1ns / 1ps

module stai_store #(
  parameter int SLOTS     = 16,
  parameter int DATA_BITS = 64,
  parameter int ID_BITS   = 16,
  parameter int IDX_W     = 4
) (
  input  logic                 clk,
  input  logic [IDX_W-1:0]     meta_raddr,
  output logic                 meta_rvalid,
  output logic [ID_BITS-1:0]   meta_rid,
  input  logic                 meta_we,
  input  logic [IDX_W-1:0]     meta_waddr,
  input  logic                 meta_wvalid,
  input  logic [ID_BITS-1:0]   meta_wid,
  input  logic [IDX_W-1:0]     data_raddr,
  output logic [DATA_BITS-1:0] data_rdata,
  input  logic                 data_we,
  input  logic [IDX_W-1:0]     data_waddr,
  input  logic [DATA_BITS-1:0] data_wdata
);

  // valid mark and id share one word
  logic [ID_BITS:0]     meta_mem [SLOTS];
  logic [DATA_BITS-1:0] data_mem [SLOTS];
  logic [ID_BITS:0]     meta_q;

  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[meta_waddr] <= {meta_wvalid, meta_wid};
    end
    meta_q <= meta_mem[meta_raddr];
  end

  always_ff @(posedge clk) begin
    if (data_we) begin
      data_mem[data_waddr] <= data_wdata;
    end
    data_rdata <= data_mem[data_raddr];
  end

  assign meta_rvalid = meta_q[ID_BITS];
  assign meta_rid    = meta_q[ID_BITS-1:0];

endmodule

FILE: sv/slot_table_auto_id.sv
`timescale 1ns / 1ps
// channel  | handshake                 | payload
// ---------+---------------------------+------------------------------------------
// request  | req_valid in, req_stall out | req: kind, record_id, payload
// response | rsp_valid out, rsp_stall in | rsp: status, result_id, read_payload, slot_index
//
// one transfer in passes an accept state, then a slot scan that reads one slot
// per cycle and stops at the first match or the last slot, then an update state
// after reset a clearing pass writes every slot empty, with req_stall high
// the response register holds a result while rsp_stall is high; the next
// request is taken meanwhile and waits in its update state

module slot_table_auto_id
  import stai_pkg::*;
#(
  parameter int SLOTS     = 16,
  parameter int DATA_BITS = 64,
  parameter int ID_BITS   = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CMP_W = (ID_BITS > 16) ? ID_BITS : 16;
  localparam logic [IDX_W-1:0]   LAST_IDX = IDX_W'(SLOTS - 1);
  localparam logic [ID_BITS-1:0] ID_ALL   = {ID_BITS{1'b1}};

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;
  localparam logic [1:0] ST_ACT   = 2'd3;

  logic [1:0]         state;
  logic [IDX_W-1:0]   scan_idx;
  logic               hit;
  req_t               cur;
  logic [ID_BITS-1:0] last_id;

  logic [IDX_W-1:0]     meta_raddr;
  logic                 meta_rvalid;
  logic [ID_BITS-1:0]   meta_rid;
  logic                 meta_we;
  logic                 meta_wvalid;
  logic [ID_BITS-1:0]   meta_wid;
  logic                 data_we;
  logic [DATA_BITS-1:0] data_rdata;
  logic                 match;
  logic                 fire;
  logic                 do_insert;
  logic [ID_BITS-1:0]   id_next;
  rsp_t                 rsp_next;

  stai_store #(
    .SLOTS     (SLOTS),
    .DATA_BITS (DATA_BITS),
    .ID_BITS   (ID_BITS),
    .IDX_W     (IDX_W)
  ) u_store (
    .clk         (clk),
    .meta_raddr  (meta_raddr),
    .meta_rvalid (meta_rvalid),
    .meta_rid    (meta_rid),
    .meta_we     (meta_we),
    .meta_waddr  (scan_idx),
    .meta_wvalid (meta_wvalid),
    .meta_wid    (meta_wid),
    .data_raddr  (scan_idx),
    .data_rdata  (data_rdata),
    .data_we     (data_we),
    .data_waddr  (scan_idx),
    .data_wdata  (DATA_BITS'(cur.payload))
  );

  assign req_stall = (state != ST_IDLE);
  assign fire      = (state == ST_ACT) && (!rsp_valid || !rsp_stall);
  assign id_next   = last_id + 1'b1;
  assign do_insert = (cur.kind == KIND_INSERT) && hit && (last_id != ID_ALL);

  always_comb begin
    if (cur.kind == KIND_INSERT) begin
      match = !meta_rvalid;
    end else begin
      match = meta_rvalid && (CMP_W'(meta_rid) == CMP_W'(cur.record_id));
    end
  end

  always_comb begin
    unique case (state)
      ST_IDLE: meta_raddr = '0;
      ST_SCAN: meta_raddr = scan_idx + 1'b1;
      default: meta_raddr = scan_idx;
    endcase
  end

  always_comb begin
    meta_we     = 1'b0;
    meta_wvalid = 1'b0;
    meta_wid    = id_next;
    data_we     = 1'b0;
    if (state == ST_CLEAR) begin
      meta_we = 1'b1;
    end else if (fire) begin
      if (do_insert) begin
        meta_we     = 1'b1;
        meta_wvalid = 1'b1;
        data_we     = 1'b1;
      end else if (hit && cur.kind == KIND_DELETE) begin
        meta_we = 1'b1;
      end else if (hit && cur.kind == KIND_MODIFY) begin
        data_we = 1'b1;
      end
    end
  end

  always_comb begin
    rsp_next.status       = STATUS_OK;
    rsp_next.result_id    = cur.record_id;
    rsp_next.read_payload = '0;
    rsp_next.slot_index   = 4'(scan_idx);
    if (cur.kind == KIND_INSERT) begin
      rsp_next.result_id = '0;
      if (!hit) begin
        rsp_next.status     = STATUS_FULL;
        rsp_next.slot_index = '0;
      end else if (last_id == ID_ALL) begin
        rsp_next.status     = STATUS_EXHAUSTED;
        rsp_next.slot_index = '0;
      end else begin
        rsp_next.result_id = 16'(id_next);
      end
    end else if (!hit) begin
      rsp_next.status     = STATUS_NOT_FOUND;
      rsp_next.slot_index = '0;
    end else if (cur.kind == KIND_READ) begin
      rsp_next.read_payload = 64'(data_rdata);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      scan_idx  <= '0;
      hit       <= 1'b0;
      last_id   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (fire) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          if (scan_idx == LAST_IDX) begin
            scan_idx <= '0;
            state    <= ST_IDLE;
          end else begin
            scan_idx <= scan_idx + 1'b1;
          end
        end
        ST_IDLE: begin
          if (req_valid) begin
            scan_idx <= '0;
            state    <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (match) begin
            hit   <= 1'b1;
            state <= ST_ACT;
          end else if (scan_idx == LAST_IDX) begin
            hit   <= 1'b0;
            state <= ST_ACT;
          end else begin
            scan_idx <= scan_idx + 1'b1;
          end
        end
        ST_ACT: begin
          if (fire) begin
            if (do_insert) begin
              last_id <= id_next;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && req_valid) begin
      cur <= req;
    end
    if (fire) begin
      rsp <= rsp_next;
    end
  end

endmodule
